@@ rtl/srem_pkg.sv @@
`timescale 1ns / 1ps

package srem_pkg;

    localparam int DATA_W  = 16;
    localparam int RAMP_W  = 32;
    localparam int STEP_W  = 29;
    localparam int GAIN_W  = 17;
    localparam int CFG_IDX_W = 3;

    localparam int ROUND_Q15 = 'h4000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_START  = 3'd0,
        REG_LEFT_TARGET = 3'd1,
        REG_LEFT_RAMP   = 3'd2,
        REG_RIGHT_TARGET = 3'd3,
        REG_RIGHT_RAMP  = 3'd4,
        REG_DRY_GAIN    = 3'd5,
        REG_WET_GAIN    = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_GAIN = 3'b010,
        S_MIX  = 3'b100
    } t_state;

    typedef struct packed {
        logic load;   // take input item, advance envelopes
        logic gain;   // form Q15 gains
        logic mix;    // write output register
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0]        frac;
        logic signed [DATA_W-1:0] vol;
    } t_env;

    // ramp / 8, truncated toward zero
    function automatic logic signed [STEP_W-1:0] ramp_to_step(
        input logic signed [RAMP_W-1:0] ramp
    );
        logic signed [RAMP_W-1:0] adj;
        begin
            adj = ramp + $signed({{(RAMP_W-3){1'b0}}, {3{ramp[RAMP_W-1]}}});
            return adj[RAMP_W-1:3];
        end
    endfunction

    function automatic t_env env_advance(
        input logic [DATA_W-1:0]        frac,
        input logic signed [STEP_W-1:0] step,
        input logic signed [DATA_W-1:0] vol,
        input logic                     falling,
        input logic signed [DATA_W-1:0] target
    );
        logic signed [STEP_W:0]   sum;
        logic signed [13:0]       carry;
        logic signed [DATA_W+1:0] v;
        logic signed [DATA_W+1:0] t;
        t_env                     res;
        begin
            sum   = $signed({{(STEP_W-DATA_W+1){1'b0}}, frac}) + $signed({step[STEP_W-1], step});
            carry = sum[STEP_W:DATA_W];
            v     = $signed({{2{vol[DATA_W-1]}}, vol})
                  + $signed({{(DATA_W-12){carry[13]}}, carry});
            t     = $signed({{2{target[DATA_W-1]}}, target});
            if (!falling) begin
                if (v > t) v = t;
            end else begin
                if (v < t) v = t;
            end
            res.frac = sum[DATA_W-1:0];
            res.vol  = v[DATA_W-1:0];
            return res;
        end
    endfunction

    // (gain * vol + 0x4000) >> 15; reaches +32768 only for -32768 * -32768
    function automatic logic signed [GAIN_W-1:0] q15_gain(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [2*DATA_W:0] p;
        begin
            p = a * b;
            p = p + ROUND_Q15;
            return p[2*DATA_W-1:DATA_W-1];
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] mix_sat(
        input logic signed [DATA_W-1:0] bus,
        input logic signed [DATA_W-1:0] src,
        input logic signed [GAIN_W-1:0] g
    );
        logic signed [DATA_W+GAIN_W:0] p;
        logic signed [GAIN_W-1:0]      term;
        logic signed [DATA_W+1:0]      s;
        begin
            p    = src * g;
            p    = p + ROUND_Q15;
            term = p[2*DATA_W-1:DATA_W-1];
            s    = $signed({{2{bus[DATA_W-1]}}, bus})
                 + $signed({term[GAIN_W-1], term});
            if (s > 18'sd32767)
                return 16'sh7fff;
            else if (s < -18'sd32768)
                return 16'sh8000;
            else
                return s[DATA_W-1:0];
        end
    endfunction

endpackage

@@ rtl/stereo_ramp_envelope_mixer_core.sv @@
// Result path: input capture, gain stage, then mix stage into the output register.
// Overlap: the gain multiply stage and the mix multiply stage run in turn, and the
//   next sample enters during the mix cycle while the output register is free.
// Reset: synchronous, active low; clears configuration, envelope state and
//   output valid. No clearing pass; ready as soon as reset is released.
`timescale 1ns / 1ps

module stereo_ramp_envelope_mixer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [srem_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [srem_pkg::RAMP_W-1:0]        i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_init_frame,
    input  logic signed [srem_pkg::DATA_W-1:0] i_right_start_volume,
    input  logic signed [srem_pkg::DATA_W-1:0] i_source_sample,
    input  logic signed [srem_pkg::DATA_W-1:0] i_main_in,
    input  logic signed [srem_pkg::DATA_W-1:0] i_aux1_in,
    input  logic signed [srem_pkg::DATA_W-1:0] i_aux2_in,
    input  logic signed [srem_pkg::DATA_W-1:0] i_aux3_in,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [srem_pkg::DATA_W-1:0] o_main_out,
    output logic signed [srem_pkg::DATA_W-1:0] o_aux1_out,
    output logic signed [srem_pkg::DATA_W-1:0] o_aux2_out,
    output logic signed [srem_pkg::DATA_W-1:0] o_aux3_out,
    output logic signed [srem_pkg::DATA_W-1:0] o_left_level,
    output logic signed [srem_pkg::DATA_W-1:0] o_right_level
);

    srem_pkg::t_cmd cmd;

    srem_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    srem_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_init_frame         (i_init_frame),
        .i_right_start_volume (i_right_start_volume),
        .i_source_sample      (i_source_sample),
        .i_main_in            (i_main_in),
        .i_aux1_in            (i_aux1_in),
        .i_aux2_in            (i_aux2_in),
        .i_aux3_in            (i_aux3_in),
        .o_main_out           (o_main_out),
        .o_aux1_out           (o_aux1_out),
        .o_aux2_out           (o_aux2_out),
        .o_aux3_out           (o_aux3_out),
        .o_left_level         (o_left_level),
        .o_right_level        (o_right_level)
    );

endmodule

@@ rtl/srem_ctrl.sv @@
`timescale 1ns / 1ps

module srem_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output srem_pkg::t_cmd o_cmd
);

    srem_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic             in_ready;
    logic             acc;
    logic             mix_fire;

    assign out_free = !r_out_valid || !i_stall;
    // next item may enter in the mix cycle, envelope state is already updated
    assign in_ready = (r_state == srem_pkg::S_IDLE) ||
                      ((r_state == srem_pkg::S_MIX) && out_free);
    assign acc      = i_valid && in_ready;
    assign mix_fire = (r_state == srem_pkg::S_MIX) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srem_pkg::S_IDLE: if (acc) n_state = srem_pkg::S_GAIN;
            srem_pkg::S_GAIN: n_state = srem_pkg::S_MIX;
            srem_pkg::S_MIX: begin
                if (mix_fire) n_state = acc ? srem_pkg::S_GAIN : srem_pkg::S_IDLE;
            end
            default: n_state = srem_pkg::S_IDLE;
        endcase
    end

    assign n_out_valid = mix_fire || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srem_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall   = !in_ready;
    assign o_valid   = r_out_valid;
    assign o_cmd.load = acc;
    assign o_cmd.gain = (r_state == srem_pkg::S_GAIN);
    assign o_cmd.mix  = mix_fire;

endmodule

@@ rtl/srem_dp.sv @@
`timescale 1ns / 1ps

module srem_dp (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  srem_pkg::t_cmd                           i_cmd,
    input  logic                                     i_cfg_we,
    input  logic [srem_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [srem_pkg::RAMP_W-1:0]              i_cfg_data,
    input  logic                                     i_init_frame,
    input  logic signed [srem_pkg::DATA_W-1:0]       i_right_start_volume,
    input  logic signed [srem_pkg::DATA_W-1:0]       i_source_sample,
    input  logic signed [srem_pkg::DATA_W-1:0]       i_main_in,
    input  logic signed [srem_pkg::DATA_W-1:0]       i_aux1_in,
    input  logic signed [srem_pkg::DATA_W-1:0]       i_aux2_in,
    input  logic signed [srem_pkg::DATA_W-1:0]       i_aux3_in,
    output logic signed [srem_pkg::DATA_W-1:0]       o_main_out,
    output logic signed [srem_pkg::DATA_W-1:0]       o_aux1_out,
    output logic signed [srem_pkg::DATA_W-1:0]       o_aux2_out,
    output logic signed [srem_pkg::DATA_W-1:0]       o_aux3_out,
    output logic signed [srem_pkg::DATA_W-1:0]       o_left_level,
    output logic signed [srem_pkg::DATA_W-1:0]       o_right_level
);

    // configuration registers
    logic signed [srem_pkg::DATA_W-1:0] r_cfg_lsv, r_cfg_lt, r_cfg_rt, r_cfg_dry, r_cfg_wet;
    logic signed [srem_pkg::RAMP_W-1:0] r_cfg_lr, r_cfg_rr;

    // envelope state
    logic [srem_pkg::DATA_W-1:0]        r_frac_l, r_frac_r;
    logic signed [srem_pkg::STEP_W-1:0] r_step_l, r_step_r;
    logic signed [srem_pkg::DATA_W-1:0] r_vol_l, r_vol_r;
    logic                               r_fall_l, r_fall_r;
    logic signed [srem_pkg::DATA_W-1:0] r_tgt_l, r_tgt_r, r_dry, r_wet;

    // captured sample and buses
    logic signed [srem_pkg::DATA_W-1:0] r_src, r_main, r_aux1, r_aux2, r_aux3;

    // gain stage
    logic signed [srem_pkg::GAIN_W-1:0] r_g_ml, r_g_mr, r_g_al, r_g_ar;

    // output register
    logic signed [srem_pkg::DATA_W-1:0] r_o_main, r_o_aux1, r_o_aux2, r_o_aux3;
    logic signed [srem_pkg::DATA_W-1:0] r_o_lvl_l, r_o_lvl_r;

    // init selection ahead of the advance
    logic [srem_pkg::DATA_W-1:0]        sel_frac_l, sel_frac_r;
    logic signed [srem_pkg::STEP_W-1:0] sel_step_l, sel_step_r;
    logic signed [srem_pkg::DATA_W-1:0] sel_vol_l, sel_vol_r, sel_tgt_l, sel_tgt_r;
    logic                               sel_fall_l, sel_fall_r;
    srem_pkg::t_env                     env_l, env_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_lsv <= '0;
            r_cfg_lt  <= '0;
            r_cfg_lr  <= '0;
            r_cfg_rt  <= '0;
            r_cfg_rr  <= '0;
            r_cfg_dry <= '0;
            r_cfg_wet <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srem_pkg::REG_LEFT_START:   r_cfg_lsv <= i_cfg_data[srem_pkg::DATA_W-1:0];
                srem_pkg::REG_LEFT_TARGET:  r_cfg_lt  <= i_cfg_data[srem_pkg::DATA_W-1:0];
                srem_pkg::REG_LEFT_RAMP:    r_cfg_lr  <= i_cfg_data;
                srem_pkg::REG_RIGHT_TARGET: r_cfg_rt  <= i_cfg_data[srem_pkg::DATA_W-1:0];
                srem_pkg::REG_RIGHT_RAMP:   r_cfg_rr  <= i_cfg_data;
                srem_pkg::REG_DRY_GAIN:     r_cfg_dry <= i_cfg_data[srem_pkg::DATA_W-1:0];
                srem_pkg::REG_WET_GAIN:     r_cfg_wet <= i_cfg_data[srem_pkg::DATA_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (i_init_frame) begin
            sel_frac_l = '0;
            sel_frac_r = '0;
            sel_step_l = srem_pkg::ramp_to_step(r_cfg_lr);
            sel_step_r = srem_pkg::ramp_to_step(r_cfg_rr);
            sel_vol_l  = r_cfg_lsv;
            sel_vol_r  = i_right_start_volume;
            sel_fall_l = r_cfg_lr[srem_pkg::RAMP_W-1];
            sel_fall_r = r_cfg_rr[srem_pkg::RAMP_W-1];
            sel_tgt_l  = r_cfg_lt;
            sel_tgt_r  = r_cfg_rt;
        end else begin
            sel_frac_l = r_frac_l;
            sel_frac_r = r_frac_r;
            sel_step_l = r_step_l;
            sel_step_r = r_step_r;
            sel_vol_l  = r_vol_l;
            sel_vol_r  = r_vol_r;
            sel_fall_l = r_fall_l;
            sel_fall_r = r_fall_r;
            sel_tgt_l  = r_tgt_l;
            sel_tgt_r  = r_tgt_r;
        end
    end

    assign env_l = srem_pkg::env_advance(sel_frac_l, sel_step_l, sel_vol_l, sel_fall_l, sel_tgt_l);
    assign env_r = srem_pkg::env_advance(sel_frac_r, sel_step_r, sel_vol_r, sel_fall_r, sel_tgt_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac_l <= '0;
            r_frac_r <= '0;
            r_step_l <= '0;
            r_step_r <= '0;
            r_vol_l  <= '0;
            r_vol_r  <= '0;
            r_fall_l <= 1'b0;
            r_fall_r <= 1'b0;
            r_tgt_l  <= '0;
            r_tgt_r  <= '0;
            r_dry    <= '0;
            r_wet    <= '0;
        end else if (i_cmd.load) begin
            r_frac_l <= env_l.frac;
            r_frac_r <= env_r.frac;
            r_vol_l  <= env_l.vol;
            r_vol_r  <= env_r.vol;
            r_step_l <= sel_step_l;
            r_step_r <= sel_step_r;
            r_fall_l <= sel_fall_l;
            r_fall_r <= sel_fall_r;
            r_tgt_l  <= sel_tgt_l;
            r_tgt_r  <= sel_tgt_r;
            if (i_init_frame) begin
                r_dry <= r_cfg_dry;
                r_wet <= r_cfg_wet;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_src  <= i_source_sample;
            r_main <= i_main_in;
            r_aux1 <= i_aux1_in;
            r_aux2 <= i_aux2_in;
            r_aux3 <= i_aux3_in;
        end
        if (i_cmd.gain) begin
            r_g_ml <= srem_pkg::q15_gain(r_dry, r_vol_l);
            r_g_mr <= srem_pkg::q15_gain(r_dry, r_vol_r);
            r_g_al <= srem_pkg::q15_gain(r_wet, r_vol_l);
            r_g_ar <= srem_pkg::q15_gain(r_wet, r_vol_r);
        end
        // sample regs and volumes still hold this item; a new load lands on the same edge
        if (i_cmd.mix) begin
            r_o_main  <= srem_pkg::mix_sat(r_main, r_src, r_g_ml);
            r_o_aux1  <= srem_pkg::mix_sat(r_aux1, r_src, r_g_mr);
            r_o_aux2  <= srem_pkg::mix_sat(r_aux2, r_src, r_g_al);
            r_o_aux3  <= srem_pkg::mix_sat(r_aux3, r_src, r_g_ar);
            r_o_lvl_l <= r_vol_l;
            r_o_lvl_r <= r_vol_r;
        end
    end

    assign o_main_out    = r_o_main;
    assign o_aux1_out    = r_o_aux1;
    assign o_aux2_out    = r_o_aux2;
    assign o_aux3_out    = r_o_aux3;
    assign o_left_level  = r_o_lvl_l;
    assign o_right_level = r_o_lvl_r;

endmodule

@@ rtl/srem_chk.sv @@
`timescale 1ns / 1ps

module srem_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic signed [srem_pkg::DATA_W-1:0] o_main_out,
    input logic signed [srem_pkg::DATA_W-1:0] o_left_level
);

    // output held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_main_out) && $stable(o_left_level))
        else $error("stalled result dropped or changed");

    // one sample at a time through the gain stage
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken in the gain cycle");

    // a fresh result always traces back to an input transfer ahead of the gain and mix stages
    a_rise_has_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 3))
        else $error("result without matching input transfer");

    // no input taken while a finished result is blocked in the mix cycle
    a_no_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> ##1 (!o_valid || !i_stall || o_stall))
        else $error("input taken while output blocked");

endmodule

bind stereo_ramp_envelope_mixer_core srem_chk u_srem_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_main_out   (o_main_out),
    .o_left_level (o_left_level)
);
